// ----- rtl/qrs_pkg.sv -----
// ============================================================================
// qrs_pkg
// Shared types and constants of the quadratic root solver.
// ============================================================================
package qrs_pkg;

    // Default coefficient format: signed Q16.16.
    localparam int COEF_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // Width of the zero tolerance register.
    localparam int TOL_WIDTH = 16;

    // Depth of the queue between the classifier and the solver.
    localparam int QUEUE_DEPTH = 4;

    // Case code returned with every result.
    typedef enum logic [2:0] {
        KIND_INFINITE = 3'd0,
        KIND_NONE     = 3'd1,
        KIND_LINEAR   = 3'd2,
        KIND_COMPLEX  = 3'd3,
        KIND_DOUBLE   = 3'd4,
        KIND_TWO_REAL = 3'd5
    } kind_t;

    // Classification of one item and the signs of its coefficients.
    typedef struct packed {
        kind_t kind;
        logic  na;
        logic  nb;
        logic  nc;
    } ctrl_t;

endpackage

// ----- rtl/qrs_fifo.sv -----
// ============================================================================
// qrs_fifo
// Small register queue that decouples the classifier from the solver.
// ============================================================================
module qrs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = qrs_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;

    assign full     = (count_reg == (AW+1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = data_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/qrs_front.sv -----
// ============================================================================
// qrs_front
// Accepts coefficient triples, forms the discriminant and classifies the case.
// ============================================================================
module qrs_front #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [qrs_pkg::TOL_WIDTH-1:0]     tol,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [COEF_WIDTH-1:0]      in_a,
    input  logic signed [COEF_WIDTH-1:0]      in_b,
    input  logic signed [COEF_WIDTH-1:0]      in_c,
    output logic                              out_valid,
    input  logic                              out_full,
    output qrs_pkg::ctrl_t                    out_ctrl,
    output logic [COEF_WIDTH-1:0]             out_ma,
    output logic [COEF_WIDTH-1:0]             out_mb,
    output logic [COEF_WIDTH-1:0]             out_mc,
    output logic [2*COEF_WIDTH:0]             out_dmag
);

    localparam int W  = COEF_WIDTH;
    localparam int XW = 2 * W + 2;

    logic en;

    logic [W-1:0] ma_c, mb_c, mc_c, tol_w;

    logic         s1_valid_reg;
    logic [W-1:0] s1_ma_reg, s1_mb_reg, s1_mc_reg;
    logic         s1_na_reg, s1_nb_reg, s1_nc_reg;

    logic           s2_valid_reg;
    logic [2*W-1:0] s2_bb_reg, s2_ac_reg;
    logic [W-1:0]   s2_ma_reg, s2_mb_reg, s2_mc_reg;
    logic           s2_na_reg, s2_nb_reg, s2_nc_reg;
    logic           s2_as_reg, s2_bs_reg, s2_cs_reg;

    logic [XW-1:0]  bbx, ac4x, dx, tolx;
    logic           dneg, dsmall;
    qrs_pkg::kind_t kind_c;

    logic           s3_valid_reg;
    qrs_pkg::ctrl_t s3_ctrl_reg;
    logic [W-1:0]   s3_ma_reg, s3_mb_reg, s3_mc_reg;
    logic [2*W:0]   s3_dmag_reg;

    // The front advances unless its finished transaction cannot enter the queue.
    assign en       = !(s3_valid_reg && out_full);
    assign in_ready = en;

    // Magnitudes of the coefficients.
    assign ma_c  = in_a[W-1] ? W'(~$unsigned(in_a) + 1'b1) : $unsigned(in_a);
    assign mb_c  = in_b[W-1] ? W'(~$unsigned(in_b) + 1'b1) : $unsigned(in_b);
    assign mc_c  = in_c[W-1] ? W'(~$unsigned(in_c) + 1'b1) : $unsigned(in_c);
    assign tol_w = W'(tol);

    // Stage 1: split into sign and magnitude.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= in_valid;
            s1_ma_reg    <= ma_c;
            s1_mb_reg    <= mb_c;
            s1_mc_reg    <= mc_c;
            s1_na_reg    <= in_a[W-1];
            s1_nb_reg    <= in_b[W-1];
            s1_nc_reg    <= in_c[W-1];
        end
    end

    // Stage 2: products for the discriminant and the near-zero tests.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s2_valid_reg <= s1_valid_reg;
            s2_bb_reg    <= s1_mb_reg * s1_mb_reg;
            s2_ac_reg    <= s1_ma_reg * s1_mc_reg;
            s2_ma_reg    <= s1_ma_reg;
            s2_mb_reg    <= s1_mb_reg;
            s2_mc_reg    <= s1_mc_reg;
            s2_na_reg    <= s1_na_reg;
            s2_nb_reg    <= s1_nb_reg;
            s2_nc_reg    <= s1_nc_reg;
            s2_as_reg    <= (s1_ma_reg <= tol_w);
            s2_bs_reg    <= (s1_mb_reg <= tol_w);
            s2_cs_reg    <= (s1_mc_reg <= tol_w);
        end
    end

    // Discriminant magnitude and sign, then the case decision.
    always_comb begin
        bbx  = XW'(s2_bb_reg);
        ac4x = {s2_ac_reg, 2'b00};
        tolx = XW'(tol) << FRAC_BITS;
        dneg = 1'b0;
        if (s2_na_reg != s2_nc_reg) begin
            dx = bbx + ac4x;
        end else if (bbx >= ac4x) begin
            dx = bbx - ac4x;
        end else begin
            dx   = ac4x - bbx;
            dneg = 1'b1;
        end
        dsmall = (dx <= tolx);

        if (s2_as_reg) begin
            if (s2_bs_reg) begin
                kind_c = s2_cs_reg ? qrs_pkg::KIND_INFINITE : qrs_pkg::KIND_NONE;
            end else begin
                kind_c = qrs_pkg::KIND_LINEAR;
            end
        end else if (dsmall) begin
            kind_c = qrs_pkg::KIND_DOUBLE;
        end else if (dneg) begin
            kind_c = qrs_pkg::KIND_COMPLEX;
        end else begin
            kind_c = qrs_pkg::KIND_TWO_REAL;
        end
    end

    // Stage 3: classified transaction waiting to enter the queue.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (en) begin
            s3_valid_reg     <= s2_valid_reg;
            s3_ctrl_reg.kind <= kind_c;
            s3_ctrl_reg.na   <= s2_na_reg;
            s3_ctrl_reg.nb   <= s2_nb_reg;
            s3_ctrl_reg.nc   <= s2_nc_reg;
            s3_ma_reg        <= s2_ma_reg;
            s3_mb_reg        <= s2_mb_reg;
            s3_mc_reg        <= s2_mc_reg;
            s3_dmag_reg      <= dx[2*W:0];
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_ctrl  = s3_ctrl_reg;
    assign out_ma    = s3_ma_reg;
    assign out_mb    = s3_mb_reg;
    assign out_mc    = s3_mc_reg;
    assign out_dmag  = s3_dmag_reg;

endmodule

// ----- rtl/qrs_div.sv -----
// ============================================================================
// qrs_div
// Pipelined restoring divider: floor(num * 2^FRAC_BITS / den), one bit a stage.
// ============================================================================
module qrs_div #(
    parameter int NUM_W     = 34,
    parameter int DEN_W     = 34,
    parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [NUM_W-1:0]             num,
    input  logic [DEN_W-1:0]             den,
    output logic [NUM_W+FRAC_BITS-1:0]   quot
);

    localparam int QW = NUM_W + FRAC_BITS;

    // Numerator bits shift out at the top while quotient bits shift in below.
    logic [QW-1:0]    nq_reg [QW+1];
    logic [DEN_W-1:0] dd_reg [QW+1];
    logic [DEN_W-1:0] rr_reg [QW+1];

    // Operand capture.
    always_ff @(posedge aclk) begin
        if (en) begin
            nq_reg[0] <= {num, FRAC_BITS'(0)};
            dd_reg[0] <= den;
            rr_reg[0] <= '0;
        end
    end

    // One quotient bit per stage.
    for (genvar j = 0; j < QW; j++) begin : g_step
        logic [DEN_W:0] rem_sh, diff;
        logic           ge;

        assign rem_sh = {rr_reg[j], nq_reg[j][QW-1]};
        assign diff   = rem_sh - {1'b0, dd_reg[j]};
        assign ge     = (rem_sh >= {1'b0, dd_reg[j]});

        always_ff @(posedge aclk) begin
            if (en) begin
                rr_reg[j+1] <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                nq_reg[j+1] <= {nq_reg[j][QW-2:0], ge};
                dd_reg[j+1] <= dd_reg[j];
            end
        end
    end

    assign quot = nq_reg[QW];

endmodule

// ----- rtl/qrs_back.sv -----
// ============================================================================
// qrs_back
// Solver pipeline: square root, two dividers and saturation of the roots.
// ============================================================================
module qrs_back #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_empty,
    output logic                          in_pop,
    input  qrs_pkg::ctrl_t                in_ctrl,
    input  logic [COEF_WIDTH-1:0]         in_ma,
    input  logic [COEF_WIDTH-1:0]         in_mb,
    input  logic [COEF_WIDTH-1:0]         in_mc,
    input  logic [2*COEF_WIDTH:0]         in_dmag,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_root_case,
    output logic signed [COEF_WIDTH-1:0]  m_root_first,
    output logic signed [COEF_WIDTH-1:0]  m_root_second,
    output logic                          m_saturated
);

    localparam int W  = COEF_WIDTH;
    localparam int SW = W + 1;          // square root bits
    localparam int RW = 2 * SW;         // radicand bits
    localparam int SR = SW + 2;         // partial remainder bits
    localparam int NW = W + 2;          // divider operand bits
    localparam int QW = NW + FRAC_BITS; // quotient bits

    typedef struct packed {
        qrs_pkg::kind_t kind;
        logic           neg1;
        logic           neg2;
        logic           use1;
        logic           use2;
    } div_ctrl_t;

    logic en;

    // Square root pipeline registers, stage 0 holds the dequeued transaction.
    logic           sv_reg   [SW+1];
    logic [RW-1:0]  rad_reg  [SW+1];
    logic [SR-1:0]  rem_reg  [SW+1];
    logic [SW-1:0]  root_reg [SW+1];
    qrs_pkg::ctrl_t sc_reg   [SW+1];
    logic [W-1:0]   sma_reg  [SW+1];
    logic [W-1:0]   smb_reg  [SW+1];
    logic [W-1:0]   smc_reg  [SW+1];

    logic [NW-1:0] qq, two_ma, n1, d1, n2, d2;
    div_ctrl_t     dctl_c;

    logic [QW-1:0] q1, q2;

    logic      dv_reg [QW+1];
    div_ctrl_t dc_reg [QW+1];

    logic [W-1:0] r1_c, r2_c;
    logic         sat1_c, sat2_c;

    logic           m_valid_reg;
    qrs_pkg::kind_t m_kind_reg;
    logic [W-1:0]   m_r1_reg, m_r2_reg;
    logic           m_sat_reg;

    // Whole pipeline holds while a result waits on the output.
    assign en     = !(m_valid_reg && !m_ready);
    assign in_pop = en && !in_empty;

    // Dequeue into the first stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sv_reg[0] <= 1'b0;
        end else if (en) begin
            sv_reg[0]   <= in_pop;
            rad_reg[0]  <= RW'(in_dmag);
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            sc_reg[0]   <= in_ctrl;
            sma_reg[0]  <= in_ma;
            smb_reg[0]  <= in_mb;
            smc_reg[0]  <= in_mc;
        end
    end

    // Digit-by-digit square root, one result bit per stage.
    for (genvar k = 0; k < SW; k++) begin : g_sqrt
        logic [SR-1:0] rem_sh, trial;
        logic          ge;

        assign rem_sh = {rem_reg[k][SW-1:0], rad_reg[k][RW-1 -: 2]};
        assign trial  = {root_reg[k], 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sv_reg[k+1] <= 1'b0;
            end else if (en) begin
                sv_reg[k+1]   <= sv_reg[k];
                rad_reg[k+1]  <= rad_reg[k] << 2;
                rem_reg[k+1]  <= ge ? rem_sh - trial : rem_sh;
                root_reg[k+1] <= {root_reg[k][SW-2:0], ge};
                sc_reg[k+1]   <= sc_reg[k];
                sma_reg[k+1]  <= sma_reg[k];
                smb_reg[k+1]  <= smb_reg[k];
                smc_reg[k+1]  <= smc_reg[k];
            end
        end
    end

    // Divider operands for each case.
    always_comb begin
        qq     = NW'(smb_reg[SW]) + NW'(root_reg[SW]);
        two_ma = NW'({sma_reg[SW], 1'b0});
        n1     = '0;
        d1     = NW'(1);
        n2     = '0;
        d2     = NW'(1);
        dctl_c.kind = sc_reg[SW].kind;
        dctl_c.neg1 = 1'b0;
        dctl_c.neg2 = 1'b0;
        dctl_c.use1 = 1'b0;
        dctl_c.use2 = 1'b0;
        case (sc_reg[SW].kind)
            qrs_pkg::KIND_LINEAR: begin
                n1          = NW'(smc_reg[SW]);
                d1          = NW'(smb_reg[SW]);
                dctl_c.neg1 = (sc_reg[SW].nc == sc_reg[SW].nb);
                dctl_c.use1 = 1'b1;
            end
            qrs_pkg::KIND_DOUBLE: begin
                n1          = NW'(smb_reg[SW]);
                d1          = two_ma;
                dctl_c.neg1 = (sc_reg[SW].nb == sc_reg[SW].na);
                dctl_c.use1 = 1'b1;
            end
            qrs_pkg::KIND_COMPLEX: begin
                n1          = NW'(smb_reg[SW]);
                d1          = two_ma;
                n2          = NW'(root_reg[SW]);
                d2          = two_ma;
                dctl_c.neg1 = (sc_reg[SW].nb == sc_reg[SW].na);
                dctl_c.neg2 = sc_reg[SW].na;
                dctl_c.use1 = 1'b1;
                dctl_c.use2 = 1'b1;
            end
            qrs_pkg::KIND_TWO_REAL: begin
                // q is negative when b is not.
                n1          = qq;
                d1          = two_ma;
                n2          = NW'({smc_reg[SW], 1'b0});
                d2          = qq;
                dctl_c.neg1 = (!sc_reg[SW].nb != sc_reg[SW].na);
                dctl_c.neg2 = (sc_reg[SW].nc != !sc_reg[SW].nb);
                dctl_c.use1 = 1'b1;
                dctl_c.use2 = 1'b1;
            end
            default: begin
            end
        endcase
    end

    qrs_div #(
        .NUM_W     (NW),
        .DEN_W     (NW),
        .FRAC_BITS (FRAC_BITS)
    ) u_div_first (
        .aclk (aclk),
        .en   (en),
        .num  (n1),
        .den  (d1),
        .quot (q1)
    );

    qrs_div #(
        .NUM_W     (NW),
        .DEN_W     (NW),
        .FRAC_BITS (FRAC_BITS)
    ) u_div_second (
        .aclk (aclk),
        .en   (en),
        .num  (n2),
        .den  (d2),
        .quot (q2)
    );

    // Case and sign information that travels alongside the dividers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg[0] <= 1'b0;
        end else if (en) begin
            dv_reg[0] <= sv_reg[SW];
            dc_reg[0] <= dctl_c;
        end
    end

    for (genvar j = 0; j < QW; j++) begin : g_delay
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[j+1] <= 1'b0;
            end else if (en) begin
                dv_reg[j+1] <= dv_reg[j];
                dc_reg[j+1] <= dc_reg[j];
            end
        end
    end

    // Clip a quotient magnitude to the signed range and apply its sign.
    function automatic logic [W:0] sat_fix(input logic [QW-1:0] q, input logic neg);
        logic [W-1:0] maxpos;
        logic [W-1:0] lim;
        logic [W-1:0] m;
        logic         sat;
        maxpos = {1'b0, {(W-1){1'b1}}};
        lim    = neg ? maxpos + 1'b1 : maxpos;
        sat    = (q > QW'(lim));
        m      = sat ? lim : q[W-1:0];
        return {sat, (neg ? W'(~m + 1'b1) : m)};
    endfunction

    // Saturation and selection of the used roots.
    always_comb begin
        {sat1_c, r1_c} = sat_fix(q1, dc_reg[QW].neg1);
        {sat2_c, r2_c} = sat_fix(q2, dc_reg[QW].neg2);
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv_reg[QW];
            m_kind_reg  <= dc_reg[QW].kind;
            m_r1_reg    <= dc_reg[QW].use1 ? r1_c : '0;
            m_r2_reg    <= dc_reg[QW].use2 ? r2_c : '0;
            m_sat_reg   <= (dc_reg[QW].use1 && sat1_c) || (dc_reg[QW].use2 && sat2_c);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_root_case   = m_kind_reg;
    assign m_root_first  = $signed(m_r1_reg);
    assign m_root_second = $signed(m_r2_reg);
    assign m_saturated   = m_sat_reg;

endmodule

// ----- rtl/quadratic_root_solver_unit.sv -----
// ============================================================================
// quadratic_root_solver_unit
// Solves a*x^2+b*x+c=0 for each coefficient triple, with case code and roots.
// ============================================================================
// Coefficients and roots are in signed Q16.16 at the default parameters.
// Throughput: one transaction per cycle while the output is not stalled, set by the
// bit-per-stage square root and the two bit-per-stage dividers of the solver pipeline.
// A stalled output holds the solver; a four-entry queue lets the classifier
// keep accepting meanwhile, until the queue fills.
// Reset clears all valid flags, the queue and the tolerance register to zero.
module quadratic_root_solver_unit #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [qrs_pkg::TOL_WIDTH-1:0]     cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [COEF_WIDTH-1:0]      s_coef_square,
    input  logic signed [COEF_WIDTH-1:0]      s_coef_linear,
    input  logic signed [COEF_WIDTH-1:0]      s_coef_const,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [2:0]                        m_root_case,
    output logic signed [COEF_WIDTH-1:0]      m_root_first,
    output logic signed [COEF_WIDTH-1:0]      m_root_second,
    output logic                              m_saturated
);

    localparam int W  = COEF_WIDTH;
    localparam int CW = $bits(qrs_pkg::ctrl_t);
    localparam int QD = CW + 3 * W + 2 * W + 1;

    logic [qrs_pkg::TOL_WIDTH-1:0] tol_reg;

    logic           f_valid, f_full, q_push, q_pop, q_empty;
    qrs_pkg::ctrl_t f_ctrl, b_ctrl;
    logic [W-1:0]   f_ma, f_mb, f_mc, b_ma, b_mb, b_mc;
    logic [2*W:0]   f_dmag, b_dmag;
    logic [QD-1:0]  q_wdata, q_rdata;

    // Tolerance register, always writable.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= '0;
        end else if (cfg_valid) begin
            tol_reg <= cfg_data;
        end
    end

    qrs_front #(
        .COEF_WIDTH (COEF_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tol       (tol_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_a      (s_coef_square),
        .in_b      (s_coef_linear),
        .in_c      (s_coef_const),
        .out_valid (f_valid),
        .out_full  (f_full),
        .out_ctrl  (f_ctrl),
        .out_ma    (f_ma),
        .out_mb    (f_mb),
        .out_mc    (f_mc),
        .out_dmag  (f_dmag)
    );

    // Queue between classifier and solver.
    assign q_push  = f_valid && !f_full;
    assign q_wdata = {f_ctrl, f_ma, f_mb, f_mc, f_dmag};
    assign {b_ctrl, b_ma, b_mb, b_mc, b_dmag} = q_rdata;

    qrs_fifo #(
        .WIDTH (QD),
        .DEPTH (qrs_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (f_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    qrs_back #(
        .COEF_WIDTH (COEF_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_empty      (q_empty),
        .in_pop        (q_pop),
        .in_ctrl       (b_ctrl),
        .in_ma         (b_ma),
        .in_mb         (b_mb),
        .in_mc         (b_mc),
        .in_dmag       (b_dmag),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_root_case   (m_root_case),
        .m_root_first  (m_root_first),
        .m_root_second (m_root_second),
        .m_saturated   (m_saturated)
    );

endmodule
